### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pfa_pkg.sv
// Package with the types, codes and constants of the paged frame allocator.
`default_nettype none

package pfa_pkg;

  localparam int IDENT_W    = 16;
  localparam int BYTES_W    = 20;
  localparam int FB_W       = 16;
  localparam int FT_W       = 10;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = 10;
  localparam int FRAG_W     = 25;
  localparam int FRAG_XW    = FRAG_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEP_W = $clog2(BYTES_W + 1);

  localparam int DEF_MAX_FRAMES = 512;
  localparam int DEF_MAX_PROCS  = 16;

  localparam logic [FB_W-1:0]   FB_RESET  = 16'd4;
  localparam logic [FT_W-1:0]   FT_RESET  = 10'd512;
  localparam logic [FRAG_W-1:0] FRAG_MAX  = 25'h1FF_FFFF;
  localparam logic [CNT_W-1:0]  COUNT_SAT = 10'd512;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_FRAME   = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_DUPLICATE  = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_TOO_FEW    = 3'd5,
    ST_NOT_FOUND  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_COUNT,
    S_FREE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DECIDE,
    S_ALLOC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               action;
    logic [IDENT_W-1:0] proc_ident;
    logic [BYTES_W-1:0] proc_bytes;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    frame_count;
    logic [CNT_W-1:0]    frames_left;
    logic [FRAG_W-1:0]   frag_total;
  } out_item_t;

  typedef struct packed {
    logic               used;
    logic [IDENT_W-1:0] owner;
  } frame_entry_t;

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [BYTES_W-1:0] bytes;
  } slot_entry_t;

  typedef struct packed {
    logic [BYTES_W-1:0] quotient;
    logic [FB_W-1:0]    remainder;
    logic               done;
  } div_result_t;

endpackage

`default_nettype wire

### design/pfa_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module pfa_divider
  import pfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [BYTES_W-1:0] dividend,
  input  wire logic [FB_W-1:0]    divisor,
  output div_result_t             result
);

  logic [BYTES_W-1:0]    quo_r, quo_nxt;
  logic [FB_W-1:0]       rem_r, rem_nxt;
  logic [FB_W-1:0]       div_r, div_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [FB_W:0]         shifted;
  logic                  fits;

  // The partial remainder stays below the divisor, so one compare and
  // subtract per step is enough.
  assign shifted = {rem_r, quo_r[BYTES_W-1]};
  assign fits    = shifted >= {1'b0, div_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[BYTES_W-2:0], fits};
      rem_nxt  = fits ? FB_W'(shifted - {1'b0, div_r}) : shifted[FB_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_STEP_W'(BYTES_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign result.quotient  = quo_r;
  assign result.remainder = rem_r;
  assign result.done      = done_r;

endmodule

`default_nettype wire

### design/pfa_frame_table.sv
// Frame table memory: used flag and owner per frame, one write and one read port.
`default_nettype none

module pfa_frame_table
  import pfa_pkg::*;
#(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int FAW        = $clog2(MAX_FRAMES)
)
(
  input  wire logic         clk,
  input  wire logic [FAW-1:0] rd_addr,
  output frame_entry_t      rd_data,
  input  wire logic         wr_en,
  input  wire logic [FAW-1:0] wr_addr,
  input  wire frame_entry_t wr_data
);

  frame_entry_t mem [MAX_FRAMES];
  frame_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/pfa_slot_table.sv
// Process slot table: used bits in flops, identifier and size in a memory.
`default_nettype none

module pfa_slot_table
  import pfa_pkg::*;
#(
  parameter int MAX_PROCS = DEF_MAX_PROCS,
  parameter int SAW       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
)
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [SAW-1:0] rd_addr,
  output logic                rd_used,
  output slot_entry_t         rd_entry,
  input  wire logic           wr_en,
  input  wire logic           clr_en,
  input  wire logic [SAW-1:0] wr_addr,
  input  wire slot_entry_t    wr_entry
);

  slot_entry_t          mem [MAX_PROCS];
  slot_entry_t          rd_entry_r;
  logic [MAX_PROCS-1:0] used_r, used_nxt;
  logic                 rd_used_r;

  always_comb begin
    used_nxt = used_r;
    if (wr_en) begin
      used_nxt[wr_addr] = 1'b1;
    end
    if (clr_en) begin
      used_nxt[wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_used_r <= 1'b0;
    end else begin
      used_r    <= used_nxt;
      rd_used_r <= used_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_used  = rd_used_r;
  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

### design/paged_frame_allocator.sv
// Top level of the paged frame allocator: sequencer, scans and result register.
//
// Each input item asks to allocate (action 0) or free (action 1) the frames of
// one process. Items arrive on in_valid/in_stall/in_data and one result item
// per input item leaves on out_valid/out_stall/out_data. Configuration writes
// arrive on cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high,
// and writes are expected only while no item is in flight.
// After reset the block walks the whole frame table once to clear it while
// in_stall stays high. An item first scans the slot table, then walks the
// frame table once through its single read port and runs the shared divider,
// one quotient bit per cycle. A successful allocate walks the frame table a
// second time to claim frames. One item is worked on at a time; in_stall is
// low only while the sequencer is idle. The finished result sits in an output
// register, so the next item is taken while it waits; if the receiver still
// stalls when the next result is ready, the sequencer holds that result until
// the register frees up.
`default_nettype none

module paged_frame_allocator
  import pfa_pkg::*;
#(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int MAX_PROCS  = DEF_MAX_PROCS
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FAW = $clog2(MAX_FRAMES);
  localparam int FCW = $clog2(MAX_FRAMES + 1);
  localparam int SAW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int SCW = $clog2(MAX_PROCS + 1);
  localparam int EW  = (FCW > FT_W) ? FCW : FT_W;
  localparam int CW  = (FCW > CNT_W) ? FCW : CNT_W;

  // Sequencer state and control decode.
  state_t state_r, state_nxt;
  logic   accept;
  logic   clear_mode;
  logic   frame_scan;
  logic   slot_scan;
  logic   div_start;
  logic   decide;
  logic   finish;

  // Configuration registers.
  logic [FB_W-1:0] fb_r, fb_nxt;
  logic [FT_W-1:0] ft_r, ft_nxt;

  // Item context.
  in_item_t           item_r, item_nxt;
  logic [FCW-1:0]     left_r, left_nxt;
  logic [FCW-1:0]     freed_r, freed_nxt;
  logic [FCW-1:0]     got_r, got_nxt;
  logic [BYTES_W-1:0] need_r, need_nxt;
  logic [FB_W-1:0]    frag_r, frag_nxt;
  logic               found_r, found_nxt;
  logic [SAW-1:0]     found_idx_r, found_idx_nxt;
  logic [BYTES_W-1:0] found_bytes_r, found_bytes_nxt;
  logic               free_ok_r, free_ok_nxt;
  logic [SAW-1:0]     free_idx_r, free_idx_nxt;
  status_t            status_r, status_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [FRAG_W-1:0]  frag_sum_r, frag_sum_nxt;

  // Scan counters and read pipelines.
  logic [FCW-1:0] fidx_r, fidx_nxt;
  logic           fpipe_vld_r, fpipe_vld_nxt;
  logic [FAW-1:0] fpipe_idx_r, fpipe_idx_nxt;
  logic [SCW-1:0] sidx_r, sidx_nxt;
  logic           spipe_vld_r, spipe_vld_nxt;
  logic [SAW-1:0] spipe_idx_r, spipe_idx_nxt;
  logic           frame_issue;
  logic           slot_issue;
  logic           frame_done;
  logic           slot_done;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      load_out;

  // Memories and divider.
  frame_entry_t       frame_rd;
  logic               frame_we;
  logic [FAW-1:0]     frame_waddr;
  frame_entry_t       frame_wdata;
  logic               slot_rd_used;
  slot_entry_t        slot_rd;
  logic               slot_we;
  logic               slot_clr;
  logic [SAW-1:0]     slot_waddr;
  slot_entry_t        slot_wentry;
  div_result_t        div_res;
  logic [BYTES_W-1:0] div_dividend;

  // Derived values.
  logic [EW-1:0]      ft_ext;
  logic [FCW-1:0]     eff_total;
  logic               pidx_in_range;
  logic               owner_match;
  logic               fb_zero;
  logic               is_alloc;
  status_t            alloc_status;
  logic               alloc_ok;
  logic [CNT_W-1:0]   need_sat;
  logic [CNT_W-1:0]   freed_sat;
  logic [FRAG_XW-1:0] sum_add;
  logic [FRAG_W-1:0]  sum_up;
  logic [FRAG_W-1:0]  sum_down;

  // Frames at or above the configured total are never counted as free or claimed.
  assign ft_ext    = EW'(ft_r);
  assign eff_total = (ft_ext >= EW'(MAX_FRAMES)) ? FCW'(MAX_FRAMES) : FCW'(ft_ext);

  assign fb_zero  = (fb_r == '0);
  assign is_alloc = (item_r.action == ACT_ALLOC);

  assign frame_issue = fidx_r < FCW'(MAX_FRAMES);
  assign slot_issue  = sidx_r < SCW'(MAX_PROCS);
  assign frame_done  = frame_scan && !frame_issue && !fpipe_vld_r;
  assign slot_done   = slot_scan && !slot_issue && !spipe_vld_r;

  assign pidx_in_range = FCW'(fpipe_idx_r) < eff_total;
  assign owner_match   = found_r && frame_rd.used && (frame_rd.owner == item_r.proc_ident);

  // Allocation checks in priority order; the first one that fails decides.
  always_comb begin
    if (left_r == '0) begin
      alloc_status = ST_NO_FRAME;
    end else if ((item_r.proc_bytes == '0) || fb_zero) begin
      alloc_status = ST_BAD_SIZE;
    end else if (found_r) begin
      alloc_status = ST_DUPLICATE;
    end else if (!free_ok_r) begin
      alloc_status = ST_TABLE_FULL;
    end else if (need_r > BYTES_W'(left_r)) begin
      alloc_status = ST_TOO_FEW;
    end else begin
      alloc_status = ST_OK;
    end
  end

  assign alloc_ok = is_alloc && (alloc_status == ST_OK);

  assign need_sat  = (need_r > BYTES_W'(COUNT_SAT)) ? COUNT_SAT : CNT_W'(need_r);
  assign freed_sat = (CW'(freed_r) > CW'(COUNT_SAT)) ? COUNT_SAT : CNT_W'(freed_r);

  // Fragmentation total saturates at its maximum going up and at zero going down.
  assign sum_add  = FRAG_XW'(frag_sum_r) + FRAG_XW'(frag_r);
  assign sum_up   = (sum_add > FRAG_XW'(FRAG_MAX)) ? FRAG_MAX : FRAG_W'(sum_add);
  assign sum_down = (frag_sum_r >= FRAG_W'(frag_r)) ? frag_sum_r - FRAG_W'(frag_r) : '0;

  assign load_out = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (!frame_issue) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        if (slot_done) begin
          state_nxt = is_alloc ? S_COUNT : S_FREE;
        end
      end
      S_COUNT, S_FREE: begin
        if (frame_done) begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_res.done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = alloc_ok ? S_ALLOC : S_DONE;
      end
      S_ALLOC: begin
        if (frame_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control decode from the state.
  always_comb begin
    in_stall   = 1'b1;
    clear_mode = 1'b0;
    slot_scan  = 1'b0;
    div_start  = 1'b0;
    decide     = 1'b0;
    finish     = 1'b0;
    frame_scan = state_r inside {S_COUNT, S_FREE, S_ALLOC};
    case (state_r)
      S_CLEAR:  clear_mode = 1'b1;
      S_IDLE:   in_stall   = 1'b0;
      S_SLOT:   slot_scan  = 1'b1;
      S_DIV_GO: div_start  = 1'b1;
      S_DECIDE: decide     = 1'b1;
      S_DONE:   finish     = 1'b1;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Datapath next values.
  always_comb begin
    fb_nxt          = fb_r;
    ft_nxt          = ft_r;
    item_nxt        = item_r;
    left_nxt        = left_r;
    freed_nxt       = freed_r;
    got_nxt         = got_r;
    need_nxt        = need_r;
    frag_nxt        = frag_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    found_bytes_nxt = found_bytes_r;
    free_ok_nxt     = free_ok_r;
    free_idx_nxt    = free_idx_r;
    status_nxt      = status_r;
    count_nxt       = count_r;
    frag_sum_nxt    = frag_sum_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r;

    frame_we    = 1'b0;
    frame_waddr = fpipe_idx_r;
    frame_wdata = frame_rd;
    slot_we     = 1'b0;
    slot_clr    = 1'b0;
    slot_waddr  = free_idx_r;
    slot_wentry.ident = item_r.proc_ident;
    slot_wentry.bytes = item_r.proc_bytes;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_BYTES: fb_nxt = cfg_data;
        CFG_FRAME_TOTAL: ft_nxt = cfg_data[FT_W-1:0];
        default: begin
          fb_nxt = fb_r;
        end
      endcase
    end

    // Scan counters run only in their states and rest at zero otherwise.
    fidx_nxt = (clear_mode || frame_scan) ? fidx_r + FCW'(frame_issue) : '0;
    fpipe_vld_nxt = frame_scan && frame_issue;
    fpipe_idx_nxt = fidx_r[FAW-1:0];
    sidx_nxt = slot_scan ? sidx_r + SCW'(slot_issue) : '0;
    spipe_vld_nxt = slot_scan && slot_issue;
    spipe_idx_nxt = sidx_r[SAW-1:0];

    if (accept) begin
      item_nxt    = in_data;
      left_nxt    = '0;
      freed_nxt   = '0;
      got_nxt     = '0;
      found_nxt   = 1'b0;
      free_ok_nxt = 1'b0;
    end

    if (clear_mode && frame_issue) begin
      frame_we    = 1'b1;
      frame_waddr = fidx_r[FAW-1:0];
      frame_wdata = '0;
    end

    // Slot scan: look for the identifier and for the first empty slot.
    if (spipe_vld_r) begin
      if (slot_rd_used && (slot_rd.ident == item_r.proc_ident)) begin
        found_nxt       = 1'b1;
        found_idx_nxt   = spipe_idx_r;
        found_bytes_nxt = slot_rd.bytes;
      end
      if (!slot_rd_used && !free_ok_r) begin
        free_ok_nxt  = 1'b1;
        free_idx_nxt = spipe_idx_r;
      end
    end

    // Frame scan, one entry per cycle from the read pipeline.
    if (fpipe_vld_r) begin
      case (state_r)
        S_COUNT: begin
          if (pidx_in_range && !frame_rd.used) begin
            left_nxt = left_r + 1'b1;
          end
        end
        S_ALLOC: begin
          if (pidx_in_range && !frame_rd.used && (BYTES_W'(got_r) < need_r)) begin
            frame_we          = 1'b1;
            frame_wdata.used  = 1'b1;
            frame_wdata.owner = item_r.proc_ident;
            got_nxt           = got_r + 1'b1;
          end
        end
        S_FREE: begin
          if (owner_match) begin
            frame_we         = 1'b1;
            frame_wdata.used = 1'b0;
            freed_nxt        = freed_r + 1'b1;
          end
          if (pidx_in_range && (!frame_rd.used || owner_match)) begin
            left_nxt = left_r + 1'b1;
          end
        end
        default: begin
          frame_we = 1'b0;
        end
      endcase
    end

    // Frames needed is the rounded-up quotient; the slack of the last frame
    // is the fragmentation. A zero frame size gives zero for both.
    if ((state_r == S_DIV_WAIT) && div_res.done) begin
      if (fb_zero) begin
        need_nxt = '0;
        frag_nxt = '0;
      end else begin
        need_nxt = div_res.quotient + BYTES_W'(div_res.remainder != '0);
        frag_nxt = (div_res.remainder != '0) ? fb_r - div_res.remainder : '0;
      end
    end

    if (decide) begin
      if (is_alloc) begin
        status_nxt = alloc_status;
        count_nxt  = need_sat;
        if (alloc_ok) begin
          slot_we      = 1'b1;
          left_nxt     = left_r - FCW'(need_r);
          frag_sum_nxt = sum_up;
        end
      end else if (found_r) begin
        status_nxt   = ST_OK;
        count_nxt    = freed_sat;
        slot_clr     = 1'b1;
        slot_waddr   = found_idx_r;
        frag_sum_nxt = sum_down;
      end else begin
        status_nxt = ST_NOT_FOUND;
        count_nxt  = '0;
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (finish && load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = status_r;
      out_data_nxt.frame_count = count_r;
      out_data_nxt.frames_left = CNT_W'(left_r);
      out_data_nxt.frag_total  = frag_sum_r;
    end
  end

  assign div_dividend = is_alloc ? item_r.proc_bytes : found_bytes_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      fb_r        <= FB_RESET;
      ft_r        <= FT_RESET;
      frag_sum_r  <= '0;
      out_valid_r <= 1'b0;
      fidx_r      <= '0;
      fpipe_vld_r <= 1'b0;
      sidx_r      <= '0;
      spipe_vld_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fb_r        <= fb_nxt;
      ft_r        <= ft_nxt;
      frag_sum_r  <= frag_sum_nxt;
      out_valid_r <= out_valid_nxt;
      fidx_r      <= fidx_nxt;
      fpipe_vld_r <= fpipe_vld_nxt;
      sidx_r      <= sidx_nxt;
      spipe_vld_r <= spipe_vld_nxt;
    end
  end

  // Item context and payload registers.
  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    left_r        <= left_nxt;
    freed_r       <= freed_nxt;
    got_r         <= got_nxt;
    need_r        <= need_nxt;
    frag_r        <= frag_nxt;
    found_r       <= found_nxt;
    found_idx_r   <= found_idx_nxt;
    found_bytes_r <= found_bytes_nxt;
    free_ok_r     <= free_ok_nxt;
    free_idx_r    <= free_idx_nxt;
    status_r      <= status_nxt;
    count_r       <= count_nxt;
    fpipe_idx_r   <= fpipe_idx_nxt;
    spipe_idx_r   <= spipe_idx_nxt;
    out_data_r    <= out_data_nxt;
  end

  pfa_frame_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .FAW        (FAW)
  ) u_frame_table (
    .clk     (clk),
    .rd_addr (fidx_r[FAW-1:0]),
    .rd_data (frame_rd),
    .wr_en   (frame_we),
    .wr_addr (frame_waddr),
    .wr_data (frame_wdata)
  );

  pfa_slot_table #(
    .MAX_PROCS (MAX_PROCS),
    .SAW       (SAW)
  ) u_slot_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (sidx_r[SAW-1:0]),
    .rd_used  (slot_rd_used),
    .rd_entry (slot_rd),
    .wr_en    (slot_we),
    .clr_en   (slot_clr),
    .wr_addr  (slot_waddr),
    .wr_entry (slot_wentry)
  );

  pfa_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (fb_r),
    .result   (div_res)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### design/pfa_checker.sv
// Port-level checker for the paged frame allocator and its bind.
`default_nettype none

`include "assert_macros.svh"

module pfa_checker
  import pfa_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // The table clearing pass keeps the input side closed right after reset.
  `ASSERT_IMP(a_stall_after_reset, clk, rst_n, $rose(rst_n), in_stall, "input open right after reset")

  // An accepted item keeps the block busy on the next cycle.
  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "block took two items back to back")

  // No result can appear in the cycle after an item is taken.
  `ASSERT_NXT(a_no_instant_result, clk, rst_n, in_valid && !in_stall, !$rose(out_valid), "result appeared without any work")

  // A new result shows up only as the sequencer returns to idle.
  `ASSERT_IMP(a_result_at_idle, clk, rst_n, $rose(out_valid), !in_stall, "result appeared while still busy")

  // A stalled result holds.
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

### tb/paged_frame_allocator_tb.sv
// Self-checking testbench of the paged frame allocator: directed table, random phases.
`default_nettype none

module paged_frame_allocator_tb;
  import pfa_pkg::*;

  localparam int MAX_FRAMES = DEF_MAX_FRAMES;
  localparam int MAX_PROCS  = DEF_MAX_PROCS;

  // Register indexes that the block does not decode; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int POOL_N      = 24;
  localparam int HOLD_CYCLES = 4000;
  localparam int QUIET_LIMIT = 40000;
  // Slowest item: a successful allocate walks the frame table twice.
  localparam int ITEM_CYCLES = 2 * MAX_FRAMES + MAX_PROCS + 30;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  always #1 clk = ~clk;

  paged_frame_allocator #(
    .MAX_FRAMES(MAX_FRAMES),
    .MAX_PROCS (MAX_PROCS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // One row of the directed table: either a register write or a request item.
  // A request row carries a typed result only where it is obvious by hand.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_item_t              item;
    bit                    typed;
    out_item_t             res;
  } dir_row_t;

  // Shadow copy of the allocator: frame table, process slots, totals and registers.
  bit                 shadow_frame_used  [MAX_FRAMES];
  logic [IDENT_W-1:0] shadow_frame_owner [MAX_FRAMES];
  bit                 shadow_slot_used   [MAX_PROCS];
  logic [IDENT_W-1:0] shadow_slot_ident  [MAX_PROCS];
  logic [BYTES_W-1:0] shadow_slot_bytes  [MAX_PROCS];
  int unsigned        shadow_frag;
  logic [FB_W-1:0]    shadow_frame_bytes;
  logic [FT_W-1:0]    shadow_frame_total;

  out_item_t          pending_results [$];
  out_item_t          oldest_result;
  dir_row_t           dir_rows [$];
  logic [IDENT_W-1:0] id_pool [POOL_N];
  int unsigned        errors;

  // Shared between the stimulus and the receiver: random idling on or off, and
  // a counter of requests for one long receiver hold-off.
  bit                 idle_en;
  int                 hold_asks;

  // Free frames below the effective total; frames at or above it never count.
  function automatic int unsigned free_below_total();
    int unsigned lim;
    int unsigned n;
    lim = (shadow_frame_total < MAX_FRAMES) ? shadow_frame_total : MAX_FRAMES;
    n = 0;
    for (int i = 0; i < lim; i++)
      if (!shadow_frame_used[i]) n++;
    return n;
  endfunction

  function automatic int find_proc(logic [IDENT_W-1:0] id);
    for (int s = 0; s < MAX_PROCS; s++)
      if (shadow_slot_used[s] && shadow_slot_ident[s] == id) return s;
    return -1;
  endfunction

  // Applies one request to the shadow state and returns the result it gives.
  function automatic out_item_t apply_request(in_item_t it);
    out_item_t   res;
    int unsigned need;
    int unsigned slack;
    int unsigned rem;
    int unsigned left;
    int unsigned got;
    int unsigned lim;
    int          slot;
    int          spare;
    res = '0;
    need = 0;
    slack = 0;
    if (it.action == ACT_ALLOC) begin
      if (shadow_frame_bytes != 0) begin
        need = it.proc_bytes / shadow_frame_bytes;
        rem  = it.proc_bytes % shadow_frame_bytes;
        if (rem != 0) begin
          need++;
          slack = shadow_frame_bytes - rem;
        end
      end
      // The needed count is reported whatever the status turns out to be.
      res.frame_count = (need > COUNT_SAT) ? COUNT_SAT : CNT_W'(need);
      left = free_below_total();
      slot = find_proc(it.proc_ident);
      spare = -1;
      for (int s = MAX_PROCS - 1; s >= 0; s--)
        if (!shadow_slot_used[s]) spare = s;
      // The checks run in a fixed order and the first one that fails wins.
      if (left == 0) begin
        res.status = ST_NO_FRAME;
      end else if (it.proc_bytes == 0 || shadow_frame_bytes == 0) begin
        res.status = ST_BAD_SIZE;
      end else if (slot >= 0) begin
        res.status = ST_DUPLICATE;
      end else if (spare < 0) begin
        res.status = ST_TABLE_FULL;
      end else if (need > left) begin
        res.status = ST_TOO_FEW;
      end else begin
        res.status = ST_OK;
        shadow_slot_used[spare]  = 1'b1;
        shadow_slot_ident[spare] = it.proc_ident;
        shadow_slot_bytes[spare] = it.proc_bytes;
        lim = (shadow_frame_total < MAX_FRAMES) ? shadow_frame_total : MAX_FRAMES;
        got = 0;
        for (int i = 0; i < lim && got < need; i++) begin
          if (!shadow_frame_used[i]) begin
            shadow_frame_used[i]  = 1'b1;
            shadow_frame_owner[i] = it.proc_ident;
            got++;
          end
        end
        if (FRAG_MAX - shadow_frag < slack) shadow_frag = FRAG_MAX;
        else shadow_frag = shadow_frag + slack;
      end
    end else begin
      slot = find_proc(it.proc_ident);
      if (slot < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        res.status = ST_OK;
        shadow_slot_used[slot] = 1'b0;
        got = 0;
        // Frames above a lowered total are still owned and are released too.
        for (int i = 0; i < MAX_FRAMES; i++) begin
          if (shadow_frame_used[i] && shadow_frame_owner[i] == it.proc_ident) begin
            shadow_frame_used[i] = 1'b0;
            got++;
          end
        end
        // The slack is recomputed with the frame size in force now.
        if (shadow_frame_bytes != 0) begin
          rem = shadow_slot_bytes[slot] % shadow_frame_bytes;
          if (rem != 0) slack = shadow_frame_bytes - rem;
        end
        shadow_frag = (shadow_frag >= slack) ? shadow_frag - slack : 0;
        res.frame_count = (got > COUNT_SAT) ? COUNT_SAT : CNT_W'(got);
      end
    end
    res.frames_left = CNT_W'(free_below_total());
    res.frag_total  = FRAG_W'(shadow_frag);
    return res;
  endfunction

  function automatic out_item_t result_of(status_t st, int unsigned cnt, int unsigned left,
                                          int unsigned frag);
    out_item_t res;
    res.status      = st;
    res.frame_count = CNT_W'(cnt);
    res.frames_left = CNT_W'(left);
    res.frag_total  = FRAG_W'(frag);
    return res;
  endfunction

  function automatic dir_row_t item_row(logic act, logic [IDENT_W-1:0] id,
                                        logic [BYTES_W-1:0] bytes, bit typed, out_item_t res);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.data = '0;
    row.item.action = act;
    row.item.proc_ident = id;
    row.item.proc_bytes = bytes;
    row.typed = typed;
    row.res = res;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    row.item = '0;
    row.typed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  // A frame total register word: the ten live bits plus random upper bits,
  // which the block must drop.
  function automatic logic [CFG_DATA_W-1:0] total_word(int unsigned ft);
    return (CFG_DATA_W'($urandom) & 16'hFC00) | CFG_DATA_W'(ft);
  endfunction

  // Random request. Most items use identifiers from a small pool, so frees
  // find live processes, duplicates happen and the slot table fills up. Sizes
  // are mostly a few dozen frames, with zero, the maximum and full-range
  // values mixed in.
  function automatic in_item_t random_request();
    in_item_t    it;
    int unsigned span;
    int unsigned pick;
    it.action = ($urandom_range(99) < 55) ? ACT_ALLOC : ACT_FREE;
    it.proc_ident = ($urandom_range(99) < 90) ? id_pool[$urandom_range(POOL_N - 1)]
                                              : IDENT_W'($urandom);
    span = ((shadow_frame_bytes == 0) ? 64 : shadow_frame_bytes) * 48;
    if (span > 20'hFFFFF) span = 20'hFFFFF;
    pick = $urandom_range(99);
    if (pick < 3)       it.proc_bytes = '0;
    else if (pick < 6)  it.proc_bytes = 20'hFFFFF;
    else if (pick < 16) it.proc_bytes = BYTES_W'($urandom);
    else                it.proc_bytes = BYTES_W'($urandom_range(span, 1));
    return it;
  endfunction

  // The block is idle once every result has been taken and it no longer
  // stalls its input. The sender drops valid first so nothing is resent.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0 || in_stall) @(negedge clk);
  endtask

  // Offers one item, with random gaps before it, and records the expected
  // result at the edge where the block takes it. Valid stays high on return,
  // so back-to-back items see no bubble.
  task automatic send_item(in_item_t it, bit typed, out_item_t res);
    out_item_t predicted;
    while (idle_en && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(it);
    pending_results.push_back(typed ? res : predicted);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FRAME_BYTES) shadow_frame_bytes = data;
    else if (idx == CFG_FRAME_TOTAL) shadow_frame_total = FT_W'(data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: stalls at random, or for one long stretch when asked, so the
  // output register and the held result fill up and the block stalls its input.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 9);
      end
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, actual %h",
                 $time, out_data);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("status", oldest_result.status, out_data.status);
        check_field("frame_count", oldest_result.frame_count, out_data.frame_count);
        check_field("frames_left", oldest_result.frames_left, out_data.frames_left);
        check_field("frag_total", oldest_result.frag_total, out_data.frag_total);
      end
    end
  end

  // Watchdog: ends the run when no handshake of any kind completes for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned fb_list [N_PHASES];
    int unsigned ft_list [N_PHASES];

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    idle_en   = 1'b1;
    hold_asks = 0;

    // The shadow starts from the reset state of the block.
    shadow_frame_bytes = FB_RESET;
    shadow_frame_total = FT_RESET;
    shadow_frag = 0;
    foreach (shadow_frame_used[i]) shadow_frame_used[i] = 1'b0;
    foreach (shadow_slot_used[s]) shadow_slot_used[s] = 1'b0;

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_N; i++) id_pool[i] = IDENT_W'($urandom);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. From reset: frame size 4, all 512 frames free.
    dir_rows.push_back(item_row(ACT_ALLOC, 16'h0001, 20'd0, 1,
                                result_of(ST_BAD_SIZE, 0, 512, 0)));
    dir_rows.push_back(item_row(ACT_FREE, 16'h0001, 20'd0, 1,
                                result_of(ST_NOT_FOUND, 0, 512, 0)));
    // Largest size: the frame count saturates and there are too few frames.
    dir_rows.push_back(item_row(ACT_ALLOC, 16'hFFFF, 20'hFFFFF, 1,
                                result_of(ST_TOO_FEW, 512, 512, 0)));
    dir_rows.push_back(item_row(ACT_ALLOC, 16'hFFFF, 20'd2044, 1,
                                result_of(ST_OK, 511, 1, 0)));
    dir_rows.push_back(item_row(ACT_ALLOC, 16'h0000, 20'd1, 1,
                                result_of(ST_OK, 1, 0, 3)));
    // Zero frame size: a free takes no slack back, and every allocate is a bad size.
    dir_rows.push_back(cfg_row(CFG_FRAME_BYTES, 16'd0));
    dir_rows.push_back(item_row(ACT_FREE, 16'hFFFF, 20'h5A5A5, 1,
                                result_of(ST_OK, 511, 511, 3)));
    dir_rows.push_back(item_row(ACT_ALLOC, 16'h0000, 20'd4, 1,
                                result_of(ST_BAD_SIZE, 0, 511, 3)));
    // A frame total above the table size is clamped.
    dir_rows.push_back(cfg_row(CFG_FRAME_BYTES, 16'd8));
    dir_rows.push_back(cfg_row(CFG_FRAME_TOTAL, 16'd1023));
    dir_rows.push_back(item_row(ACT_ALLOC, 16'h0002, 20'd9, 1,
                                result_of(ST_OK, 2, 509, 10)));
    // Total lowered below the frames in use: nothing left, yet frees still
    // release the frames above it, and the slack sum stops at zero.
    dir_rows.push_back(cfg_row(CFG_FRAME_TOTAL, 16'd2));
    dir_rows.push_back(item_row(ACT_ALLOC, 16'h0003, 20'd1, 1,
                                result_of(ST_NO_FRAME, 1, 0, 10)));
    dir_rows.push_back(item_row(ACT_FREE, 16'h0002, 20'd0, 1,
                                result_of(ST_OK, 2, 2, 3)));
    dir_rows.push_back(item_row(ACT_FREE, 16'h0000, 20'd0, 1,
                                result_of(ST_OK, 1, 2, 0)));
    // Fill every slot, then one more allocate finds the table full.
    dir_rows.push_back(cfg_row(CFG_FRAME_BYTES, 16'd4));
    dir_rows.push_back(cfg_row(CFG_FRAME_TOTAL, 16'd512));
    for (int k = 0; k < MAX_PROCS; k++)
      dir_rows.push_back(item_row(ACT_ALLOC, IDENT_W'(16'h0100 + k), BYTES_W'(4 * k + 1),
                                  0, '0));
    dir_rows.push_back(item_row(ACT_ALLOC, 16'h0200, 20'd4, 1,
                                result_of(ST_TABLE_FULL, 1, 376, 48)));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases, each under its own register setting. Processes stay alive
    // across phases, so frame size and total also change under live processes.
    fb_list = '{4, 1, 16'hFFFF, $urandom_range(300, 2), 0, 8, 3, 4,
                $urandom_range(16'hFFFF, 1), 2};
    ft_list = '{512, 512, 512, $urandom_range(511, 1), 1023, 0, 1, 40, 512, 512};
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_FRAME_BYTES, CFG_DATA_W'(fb_list[p]));
      write_reg(CFG_FRAME_TOTAL, total_word(ft_list[p]));
      if (p == 3) write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
      if (p == 7) write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
      // One phase runs flat out on both sides; another opens with a long hold-off.
      idle_en = (p != 1);
      if (p == 2) hold_asks++;
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_request(), 0, '0);
    end

    wait_idle();
    // Watch a little longer for any stray result.
    repeat (ITEM_CYCLES) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
